[src/brf_pkg.sv]
// Shared constants, types and helpers for the block ring FIFO.
package brf_pkg;

	localparam int DEPTH   = 64;
	localparam int BLOCK_W = 32;
	localparam int PTR_W   = $clog2(DEPTH);
	localparam int FILL_W  = $clog2(DEPTH + 1);
	localparam int CAP_W   = 7;
	localparam int REQ_W   = 7;
	localparam int CMD_W   = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE  = 3'd0,
		CMD_FWRITE = 3'd1,
		CMD_READ   = 3'd2,
		CMD_PEEK   = 3'd3,
		CMD_FLUSH  = 3'd4
	} cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic [BLOCK_W-1:0] block;
		logic               has;
		logic               last;
		logic               acc;
		logic               drop;
		logic [FILL_W-1:0]  fill;
	} res_t;

	typedef struct packed {
		logic               we;
		logic [PTR_W-1:0]   waddr;
		logic [BLOCK_W-1:0] wdata;
		logic               re;
		logic [PTR_W-1:0]   raddr;
	} ram_req_t;

	// Pointer step that wraps at the effective capacity.
	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p,
			input logic [FILL_W-1:0] cap);
		logic [FILL_W-1:0] n;
		n = FILL_W'(p) + FILL_W'(1);
		return (n >= cap) ? '0 : n[PTR_W-1:0];
	endfunction

endpackage

[src/block_ring_fifo.sv]
// Block ring FIFO top level: store, sequencer and output register.
//
// A circular FIFO of 32-bit blocks with a programmable slot count (capacity,
// 0 treated as 1, above 64 treated as 64); writing capacity also empties the
// FIFO. Write, force write, flush and unknown commands produce one result beat
// each and stream at one item per cycle while out_ready is high. A read or
// peek of n blocks (n = min(request_count, fill level)) produces n beats, one
// per cycle while out_ready is high; it holds the block from acceptance, while
// each block passes through the single read port of the store, until the last
// block drains from the read stage. An empty read or peek, or one with a count
// of zero, gives a single beat with no data. The result register takes a new
// beat in the cycle the previous one is taken, so a result held by a low
// out_ready also holds off the input.
module block_ring_fifo
	import brf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CAP_W-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [CMD_W-1:0]   command,
	input  logic [BLOCK_W-1:0] block_in,
	input  logic [REQ_W-1:0]   request_count,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [BLOCK_W-1:0] block_out,
	output logic               has_block,
	output logic               last_of_run,
	output logic               accepted,
	output logic               dropped_oldest,
	output logic [FILL_W-1:0]  fill_level
);

	ram_req_t           ram_req;
	logic [BLOCK_W-1:0] ram_rdata;
	logic               res_valid, out_free, out_valid_q;
	res_t               res, res_q;

	assign out_free = !out_valid_q || out_ready;

	brf_ram #(
		.ADDR_W(PTR_W),
		.DATA_W(BLOCK_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_req.we),
		.waddr(ram_req.waddr),
		.wdata(ram_req.wdata),
		.re   (ram_req.re),
		.raddr(ram_req.raddr),
		.rdata(ram_rdata)
	);

	brf_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.block_in     (block_in),
		.request_count(request_count),
		.out_free     (out_free),
		.ram_req      (ram_req),
		.ram_rdata    (ram_rdata),
		.res_valid    (res_valid),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign block_out      = res_q.block;
	assign has_block      = res_q.has;
	assign last_of_run    = res_q.last;
	assign accepted       = res_q.acc;
	assign dropped_oldest = res_q.drop;
	assign fill_level     = res_q.fill;

endmodule

[src/brf_ram.sv]
// Single-port-write, single-port-read block store with registered read data.
module brf_ram #(
	parameter int ADDR_W = 6,
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds while re is low, so a stalled beat stays put.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/brf_ctrl.sv]
// Command sequencer: pointers, fill count, capacity and the read scan stage.
module brf_ctrl
	import brf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CAP_W-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [CMD_W-1:0]   command,
	input  logic [BLOCK_W-1:0] block_in,
	input  logic [REQ_W-1:0]   request_count,
	input  logic               out_free,
	output ram_req_t           ram_req,
	input  logic [BLOCK_W-1:0] ram_rdata,
	output logic               res_valid,
	output res_t               res
);

	state_t             state_q, state_d;
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q, scan_ptr_q;
	logic [FILL_W-1:0]  fill_q, rem_q;
	logic [CAP_W-1:0]   cap_q;
	logic               peek_q;

	logic               rv_s1, last_s1;
	logic [FILL_W-1:0]  fill_s1;

	logic [FILL_W-1:0]  cap_eff, n_req, fill_after;
	logic               accept, start_scan, issue, s1_move;
	logic               is_wr, is_rd, full, drop, acc;
	logic [PTR_W-1:0]   scan_next;

	always_comb begin
		if (cap_q == '0) begin
			cap_eff = FILL_W'(1);
		end else if (int'(cap_q) > DEPTH) begin
			cap_eff = FILL_W'(DEPTH);
		end else begin
			cap_eff = FILL_W'(cap_q);
		end
	end

	assign is_wr = (command == CMD_WRITE) || (command == CMD_FWRITE);
	assign is_rd = (command == CMD_READ) || (command == CMD_PEEK);
	assign full  = fill_q >= cap_eff;
	assign drop  = full && (command == CMD_FWRITE);
	assign acc   = !full || drop;
	assign fill_after = fill_q - FILL_W'(drop) + FILL_W'(acc);

	always_comb begin
		if (int'(request_count) < int'(fill_q)) begin
			n_req = FILL_W'(request_count);
		end else begin
			n_req = fill_q;
		end
	end

	assign s1_move    = rv_s1 && out_free;
	assign accept     = in_valid && in_ready;
	assign start_scan = accept && is_rd && (n_req != '0);
	assign scan_next  = ptr_next(scan_ptr_q, cap_eff);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start_scan) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (issue && rem_q == FILL_W'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready = 1'b0;
		issue    = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = !rv_s1 && out_free;
			ST_RUN:  issue    = !rv_s1 || out_free;
			default: begin
				in_ready = 1'b0;
				issue    = 1'b0;
			end
		endcase
	end

	always_comb begin
		ram_req.we    = accept && is_wr && acc;
		ram_req.waddr = wr_ptr_q;
		ram_req.wdata = block_in;
		ram_req.re    = issue;
		ram_req.raddr = scan_ptr_q;
	end

	// Result: a scanned block leaving s1, or the single beat of any other item.
	always_comb begin
		res_valid = s1_move || (accept && !start_scan);
		res       = '0;
		res.last  = 1'b1;
		res.fill  = fill_q;
		if (rv_s1) begin
			res.block = ram_rdata;
			res.has   = 1'b1;
			res.last  = last_s1;
			res.fill  = fill_s1;
		end else begin
			case (command)
				CMD_WRITE, CMD_FWRITE: begin
					res.acc  = acc;
					res.drop = drop;
					res.fill = fill_after;
				end
				CMD_FLUSH: res.fill = '0;
				default:   res.fill = fill_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			scan_ptr_q <= '0;
			fill_q     <= '0;
			rem_q      <= '0;
			cap_q      <= CAP_W'(64);
			peek_q     <= 1'b0;
			rv_s1      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				cap_q    <= cfg_data;
				wr_ptr_q <= '0;
				rd_ptr_q <= '0;
				fill_q   <= '0;
			end else if (accept) begin
				case (command)
					CMD_WRITE, CMD_FWRITE: begin
						if (drop) begin
							rd_ptr_q <= ptr_next(rd_ptr_q, cap_eff);
						end
						if (acc) begin
							wr_ptr_q <= ptr_next(wr_ptr_q, cap_eff);
						end
						fill_q <= fill_after;
					end
					CMD_READ, CMD_PEEK: begin
						scan_ptr_q <= rd_ptr_q;
						rem_q      <= n_req;
						peek_q     <= (command == CMD_PEEK);
					end
					CMD_FLUSH: begin
						wr_ptr_q <= '0;
						rd_ptr_q <= '0;
						fill_q   <= '0;
					end
					default: ;
				endcase
			end else if (issue) begin
				scan_ptr_q <= scan_next;
				rem_q      <= rem_q - FILL_W'(1);
				if (!peek_q) begin
					rd_ptr_q <= scan_next;
					fill_q   <= fill_q - FILL_W'(1);
				end
			end

			if (issue) begin
				rv_s1 <= 1'b1;
			end else if (s1_move) begin
				rv_s1 <= 1'b0;
			end
		end
	end

	// s1 payload travels alongside the store's registered read data
	always_ff @(posedge clk) begin
		if (issue) begin
			last_s1 <= (rem_q == FILL_W'(1));
			fill_s1 <= peek_q ? fill_q : fill_q - FILL_W'(1);
		end
	end

endmodule
